// File: rtl/one_wire_bus_master_assert.svh
// Assertion helpers for the RTL of the bus master; owbm_seq is the file that includes them.
// Every check samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// The consequent must hold on the same clock edge as the antecedent.
`define OWBM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold on the clock edge after the antecedent.
`define OWBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: rtl/owbm_pkg.sv
package owbm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_RST_LOW     = 4'd1,
    PH_RST_WAIT    = 4'd2,
    PH_RST_RECOVER = 4'd3,
    PH_W_LOW       = 4'd4,
    PH_W_HIGH      = 4'd5,
    PH_R_LOW       = 4'd6,
    PH_R_WAIT      = 4'd7,
    PH_R_END       = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    LINE_REL  = 2'd0,
    LINE_LOW  = 2'd1,
    LINE_HIGH = 2'd2
  } line_e;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_RESET_SAMPLE  = 3'd1,
    CFG_RESET_RECOVER = 3'd2,
    CFG_W1_LOW        = 3'd3,
    CFG_W1_HIGH       = 3'd4,
    CFG_W0_LOW        = 3'd5,
    CFG_W0_HIGH       = 3'd6,
    CFG_READ_SLOT     = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 48;
  localparam int unsigned DurWidth     = 16;
  localparam logic [2:0]  BitLast      = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       bus_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] bus_drive;
    logic       busy_res;
    logic       done_res;
    logic       present_res;
    logic [7:0] read_byte;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [DurWidth-1:0] reset_low;
    logic [DurWidth-1:0] reset_sample;
    logic [DurWidth-1:0] reset_recover;
    logic [DurWidth-1:0] w1_low;
    logic [DurWidth-1:0] w1_high;
    logic [DurWidth-1:0] w0_low;
    logic [DurWidth-1:0] w0_high;
    logic [DurWidth-1:0] rd_low;
    logic [DurWidth-1:0] rd_sample;
    logic [DurWidth-1:0] rd_end;
  } timing_t;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] op;
    logic [7:0] shift;
    logic [2:0] bit_idx;
    logic       presence;
    line_e      line;
  } seq_state_t;

  // Duration of the current phase; a low phase never lasts less than one tick.
  function automatic logic [DurWidth-1:0] phase_dur(seq_state_t s, timing_t t);
    logic [DurWidth-1:0] d;
    logic                low;
    low = 1'b0;
    case (s.phase)
      PH_RST_LOW: begin
        d   = t.reset_low;
        low = 1'b1;
      end
      PH_RST_WAIT:    d = t.reset_sample;
      PH_RST_RECOVER: d = t.reset_recover;
      PH_W_LOW: begin
        d   = s.shift[0] ? t.w1_low : t.w0_low;
        low = 1'b1;
      end
      PH_W_HIGH:      d = s.shift[0] ? t.w1_high : t.w0_high;
      PH_R_LOW: begin
        d   = t.rd_low;
        low = 1'b1;
      end
      PH_R_WAIT:      d = t.rd_sample;
      default:        d = t.rd_end;
    endcase
    if (low && (d == '0)) begin
      d = DurWidth'(1);
    end
    return d;
  endfunction

  // State after the current phase runs out.
  function automatic seq_state_t end_phase(seq_state_t s, logic level);
    seq_state_t r;
    logic       fin;
    r   = s;
    fin = 1'b0;
    case (s.phase)
      PH_RST_LOW: begin
        r.phase = PH_RST_WAIT;
        r.line  = LINE_REL;
      end
      PH_RST_WAIT: begin
        r.presence = ~level;
        r.phase    = PH_RST_RECOVER;
        r.line     = LINE_REL;
      end
      PH_W_LOW: begin
        r.phase = PH_W_HIGH;
        r.line  = LINE_HIGH;
      end
      PH_W_HIGH: begin
        r.shift = {1'b0, s.shift[7:1]};
        if (s.bit_idx == BitLast) begin
          fin = 1'b1;
        end else begin
          r.bit_idx = s.bit_idx + 3'd1;
          r.phase   = PH_W_LOW;
          r.line    = LINE_LOW;
        end
      end
      PH_R_LOW: begin
        r.phase = PH_R_WAIT;
        r.line  = LINE_REL;
      end
      PH_R_WAIT: begin
        r.shift = {level, s.shift[7:1]};
        r.phase = PH_R_END;
        r.line  = LINE_REL;
      end
      PH_R_END: begin
        if (s.bit_idx == BitLast) begin
          fin = 1'b1;
        end else begin
          r.bit_idx = s.bit_idx + 3'd1;
          r.phase   = PH_R_LOW;
          r.line    = LINE_LOW;
        end
      end
      default: fin = 1'b1;
    endcase
    if (fin) begin
      r.phase   = PH_IDLE;
      r.line    = LINE_REL;
      r.bit_idx = '0;
    end
    return r;
  endfunction

endpackage

// File: rtl/owbm_cfg.sv
module owbm_cfg import owbm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [CfgIdxWidth-1:0]  index_i,
  input  logic [CfgDataWidth-1:0] data_i,
  output timing_t                 timing_o
);

  timing_t timing_q, timing_d;

  always_comb begin
    timing_d = timing_q;
    if (we_i) begin
      case (index_i)
        CFG_RESET_LOW:     timing_d.reset_low     = data_i[DurWidth-1:0];
        CFG_RESET_SAMPLE:  timing_d.reset_sample  = data_i[DurWidth-1:0];
        CFG_RESET_RECOVER: timing_d.reset_recover = data_i[DurWidth-1:0];
        CFG_W1_LOW:        timing_d.w1_low        = data_i[DurWidth-1:0];
        CFG_W1_HIGH:       timing_d.w1_high       = data_i[DurWidth-1:0];
        CFG_W0_LOW:        timing_d.w0_low        = data_i[DurWidth-1:0];
        CFG_W0_HIGH:       timing_d.w0_high       = data_i[DurWidth-1:0];
        CFG_READ_SLOT: begin
          timing_d.rd_low    = data_i[15:0];
          timing_d.rd_sample = data_i[31:16];
          timing_d.rd_end    = data_i[47:32];
        end
        default: timing_d = timing_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.reset_low     <= 16'd480;
      timing_q.reset_sample  <= 16'd70;
      timing_q.reset_recover <= 16'd410;
      timing_q.w1_low        <= 16'd6;
      timing_q.w1_high       <= 16'd64;
      timing_q.w0_low        <= 16'd60;
      timing_q.w0_high       <= 16'd10;
      timing_q.rd_low        <= 16'd6;
      timing_q.rd_sample     <= 16'd9;
      timing_q.rd_end        <= 16'd55;
    end else begin
      timing_q <= timing_d;
    end
  end

  assign timing_o = timing_q;

endmodule

// File: rtl/owbm_seq.sv
module owbm_seq import owbm_pkg::*; #(
  parameter int unsigned TickCountWidth = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  in_item_t  item_i,
  input  timing_t   timing_i,
  output out_item_t res_o
);

  `include "one_wire_bus_master_assert.svh"

  localparam int unsigned XW = (TickCountWidth > DurWidth) ? TickCountWidth : DurWidth;
  localparam logic [TickCountWidth-1:0] TickMax = {TickCountWidth{1'b1}};

  seq_state_t                state_q, state_d;
  logic [TickCountWidth-1:0] tick_q, tick_d;

  seq_state_t                s1, s2, s3;
  logic [TickCountWidth-1:0] tick_inc;
  logic                      end1, end2, end3;
  logic                      done, rejected;

  always_comb begin
    state_d  = state_q;
    tick_d   = tick_q;
    done     = 1'b0;
    rejected = 1'b0;
    tick_inc = (tick_q != TickMax) ? tick_q + 1'b1 : tick_q;
    end1     = (XW'(tick_inc) >= XW'(phase_dur(state_q, timing_i))) || (tick_inc == TickMax);
    s1       = end1 ? end_phase(state_q, item_i.bus_level) : state_q;
    end2     = end1 && (s1.phase != PH_IDLE) && (phase_dur(s1, timing_i) == '0);
    s2       = end2 ? end_phase(s1, item_i.bus_level) : s1;
    end3     = end2 && (s2.phase != PH_IDLE) && (phase_dur(s2, timing_i) == '0);
    s3       = end3 ? end_phase(s2, item_i.bus_level) : s2;
    if (item_i.kind != KIND_TICK) begin
      if (state_q.phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        state_d.op      = item_i.kind;
        state_d.bit_idx = '0;
        state_d.line    = LINE_LOW;
        tick_d          = '0;
        case (item_i.kind)
          KIND_RESET: state_d.phase = PH_RST_LOW;
          KIND_WRITE: begin
            state_d.phase = PH_W_LOW;
            state_d.shift = item_i.data_byte;
          end
          default: begin
            state_d.phase = PH_R_LOW;
            state_d.shift = '0;
          end
        endcase
      end
    end else if (state_q.phase != PH_IDLE) begin
      state_d = s3;
      tick_d  = end1 ? '0 : tick_inc;
      done    = (s3.phase == PH_IDLE);
    end
  end

  always_comb begin
    res_o.bus_drive   = state_d.line;
    res_o.busy_res    = (state_d.phase != PH_IDLE);
    res_o.done_res    = done;
    res_o.present_res = state_d.presence;
    res_o.read_byte   = ((state_d.op == KIND_READ) && (state_d.phase == PH_IDLE)) ?
                        state_d.shift : '0;
    res_o.rejected    = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase    <= PH_IDLE;
      state_q.op       <= '0;
      state_q.shift    <= '0;
      state_q.bit_idx  <= '0;
      state_q.presence <= 1'b0;
      state_q.line     <= LINE_REL;
      tick_q           <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
      tick_q  <= tick_d;
    end
  end

  `OWBM_ASSERT_SAME(a_done_needs_busy, advance_i && res_o.done_res, state_q.phase != PH_IDLE)
  `OWBM_ASSERT_NEXT(a_reject_holds, advance_i && res_o.rejected, state_q == $past(state_q))
  `OWBM_ASSERT_SAME(a_idle_released, state_q.phase == PH_IDLE, state_q.line == LINE_REL)
  `OWBM_ASSERT_SAME(a_idle_count_clear, state_q.phase == PH_IDLE, tick_q == '0)

endmodule

// File: rtl/one_wire_bus_master.sv
// An accepted input word waits in the input register; its result word is registered
// and offered from the output register once that register is free. Throughput: one
// input word per cycle while results are taken; the input register, the sequencer
// logic and the output register form a two-stage pipeline that never needs a bubble.
// Reset: rst_ni clears the sequencer to idle with the line released and loads the
// default timing registers; both pipeline stages come up empty.
module one_wire_bus_master import owbm_pkg::*; #(
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_item_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_item_t               out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  timing_t   timing;
  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_item_t out_q, res;
  logic      out_vld_q, out_vld_d;
  logic      advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign in_vld_d    = (in_valid_i && in_ready_o) || (in_vld_q && !advance);
  assign out_vld_d   = advance || (out_vld_q && !out_ready_i);

  owbm_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (cfg_valid_i && cfg_ready_o),
    .index_i  (cfg_index_i),
    .data_i   (cfg_data_i),
    .timing_o (timing)
  );

  owbm_seq #(
    .TickCountWidth (TICK_COUNT_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .timing_i  (timing),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: test/one_wire_bus_master_check.sv
`timescale 1ns / 100ps

module one_wire_bus_master_check import owbm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  in_item_t                in_data_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  out_item_t               out_data_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output int                      err_count_o,
  output int                      pending_o,
  output int                      checked_o,
  output int                      cmd_count_o,
  output int                      reject_count_o,
  output logic                    seq_busy_o
);

  typedef struct packed {
    phase_e      stage;
    kind_e       op;
    logic [15:0] ticks;
    logic [2:0]  bit_pos;
    logic [7:0]  shreg;
    logic        present;
    line_e       drive;
  } bus_state_t;

  typedef struct packed {
    bus_state_t s;
    out_item_t  o;
  } step_t;

  localparam bus_state_t StateReset = '{
    stage: PH_IDLE, op: KIND_TICK, ticks: '0, bit_pos: '0, shreg: '0,
    present: 1'b0, drive: LINE_REL
  };

  localparam logic [7:0][CfgDataWidth-1:0] TimingReset = {
    48'd236223791110, 48'd10, 48'd60, 48'd64, 48'd6, 48'd410, 48'd70, 48'd480
  };

  bus_state_t                    state;
  logic [7:0][CfgDataWidth-1:0]  timing;
  out_item_t                     bus_words_due[$];
  int                            errs = 0;
  int                            checked = 0;
  int                            cmds = 0;
  int                            rejects = 0;

  function automatic logic [15:0] slot_ticks(bus_state_t s,
                                             logic [7:0][CfgDataWidth-1:0] tm);
    logic [15:0] d;
    logic        low;
    low = 1'b0;
    case (s.stage)
      PH_RST_LOW: begin
        d   = tm[CFG_RESET_LOW][15:0];
        low = 1'b1;
      end
      PH_RST_WAIT:    d = tm[CFG_RESET_SAMPLE][15:0];
      PH_RST_RECOVER: d = tm[CFG_RESET_RECOVER][15:0];
      PH_W_LOW: begin
        d   = s.shreg[0] ? tm[CFG_W1_LOW][15:0] : tm[CFG_W0_LOW][15:0];
        low = 1'b1;
      end
      PH_W_HIGH:      d = s.shreg[0] ? tm[CFG_W1_HIGH][15:0] : tm[CFG_W0_HIGH][15:0];
      PH_R_LOW: begin
        d   = tm[CFG_READ_SLOT][15:0];
        low = 1'b1;
      end
      PH_R_WAIT:      d = tm[CFG_READ_SLOT][31:16];
      default:        d = tm[CFG_READ_SLOT][47:32];
    endcase
    if (low && d == '0) begin
      d = 16'd1;
    end
    return d;
  endfunction

  function automatic step_t next_bus_state(bus_state_t cur, in_item_t x,
                                           logic [7:0][CfgDataWidth-1:0] tm);
    step_t r;
    logic  done;
    logic  fin;
    r.s  = cur;
    r.o  = '0;
    done = 1'b0;
    if (x.kind != KIND_TICK) begin
      if (cur.stage != PH_IDLE) begin
        r.o.rejected = 1'b1;
      end else begin
        r.s.op      = kind_e'(x.kind);
        r.s.ticks   = '0;
        r.s.bit_pos = '0;
        r.s.drive   = LINE_LOW;
        case (x.kind)
          KIND_RESET: r.s.stage = PH_RST_LOW;
          KIND_WRITE: begin
            r.s.stage = PH_W_LOW;
            r.s.shreg = x.data_byte;
          end
          default: begin
            r.s.stage = PH_R_LOW;
            r.s.shreg = '0;
          end
        endcase
      end
    end else if (cur.stage != PH_IDLE) begin
      if (r.s.ticks != '1) begin
        r.s.ticks = r.s.ticks + 16'd1;
      end
      while (r.s.stage != PH_IDLE && r.s.ticks >= slot_ticks(r.s, tm)) begin
        r.s.ticks = '0;
        fin       = 1'b0;
        case (r.s.stage)
          PH_RST_LOW: begin
            r.s.stage = PH_RST_WAIT;
            r.s.drive = LINE_REL;
          end
          PH_RST_WAIT: begin
            r.s.present = ~x.bus_level;
            r.s.stage   = PH_RST_RECOVER;
            r.s.drive   = LINE_REL;
          end
          PH_W_LOW: begin
            r.s.stage = PH_W_HIGH;
            r.s.drive = LINE_HIGH;
          end
          PH_W_HIGH: begin
            r.s.shreg = r.s.shreg >> 1;
            if (r.s.bit_pos == BitLast) begin
              fin = 1'b1;
            end else begin
              r.s.bit_pos = r.s.bit_pos + 3'd1;
              r.s.stage   = PH_W_LOW;
              r.s.drive   = LINE_LOW;
            end
          end
          PH_R_LOW: begin
            r.s.stage = PH_R_WAIT;
            r.s.drive = LINE_REL;
          end
          PH_R_WAIT: begin
            r.s.shreg = {x.bus_level, r.s.shreg[7:1]};
            r.s.stage = PH_R_END;
            r.s.drive = LINE_REL;
          end
          PH_R_END: begin
            if (r.s.bit_pos == BitLast) begin
              fin = 1'b1;
            end else begin
              r.s.bit_pos = r.s.bit_pos + 3'd1;
              r.s.stage   = PH_R_LOW;
              r.s.drive   = LINE_LOW;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          r.s.stage   = PH_IDLE;
          r.s.drive   = LINE_REL;
          r.s.bit_pos = '0;
          done        = 1'b1;
        end
      end
    end
    r.o.bus_drive   = r.s.drive;
    r.o.busy_res    = r.s.stage != PH_IDLE;
    r.o.done_res    = done;
    r.o.present_res = r.s.present;
    r.o.read_byte   = (r.s.op == KIND_READ && r.s.stage == PH_IDLE) ? r.s.shreg : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    step_t                        st;
    out_item_t                    want;
    logic [7:0][CfgDataWidth-1:0] tm;
    if (!rst_ni) begin
      state     <= StateReset;
      timing    <= TimingReset;
      pending_o <= 0;
      bus_words_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (bus_words_due.size() == 0) begin
          $error("Result word arrived with none pending.");
          errs++;
        end else begin
          want = bus_words_due.pop_front();
          checked++;
          if (out_data_i.bus_drive !== want.bus_drive) begin
            $error("bus_drive: expected %0d, got %0d", want.bus_drive, out_data_i.bus_drive);
            errs++;
          end
          if (out_data_i.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, out_data_i.busy_res);
            errs++;
          end
          if (out_data_i.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, out_data_i.done_res);
            errs++;
          end
          if (out_data_i.present_res !== want.present_res) begin
            $error("present_res: expected %0d, got %0d", want.present_res,
                   out_data_i.present_res);
            errs++;
          end
          if (out_data_i.read_byte !== want.read_byte) begin
            $error("read_byte: expected %0h, got %0h", want.read_byte, out_data_i.read_byte);
            errs++;
          end
          if (out_data_i.rejected !== want.rejected) begin
            $error("rejected: expected %0d, got %0d", want.rejected, out_data_i.rejected);
            errs++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        tm = timing;
        tm[cfg_index_i] = (cfg_index_i == CFG_READ_SLOT) ? cfg_data_i :
                          CfgDataWidth'(cfg_data_i[15:0]);
        timing <= tm;
      end
      if (in_valid_i && in_ready_i) begin
        st = next_bus_state(state, in_data_i, timing);
        state <= st.s;
        bus_words_due.push_back(st.o);
        if (in_data_i.kind != KIND_TICK) begin
          if (st.o.rejected) begin
            rejects++;
          end else begin
            cmds++;
          end
        end
      end
      pending_o <= bus_words_due.size();
    end
  end

  assign err_count_o    = errs;
  assign checked_o      = checked;
  assign cmd_count_o    = cmds;
  assign reject_count_o = rejects;
  assign seq_busy_o     = state.stage != PH_IDLE;

endmodule

// File: test/one_wire_bus_master_test.sv
`timescale 1ns / 100ps

module one_wire_bus_master_test;
  import owbm_pkg::*;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  in_item_t                     in_data;
  logic                         out_valid;
  logic                         out_ready;
  out_item_t                    out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CfgIdxWidth-1:0]       cfg_index;
  logic [CfgDataWidth-1:0]      cfg_data;

  int                           errors;
  int                           pending;
  int                           checked;
  int                           cmds;
  int                           rejects;
  logic                         busy;

  logic [7:0][CfgDataWidth-1:0] slot_cfg;
  int                           sent = 0;
  int                           settings_n = 0;
  int                           stall_seq = 0;
  int                           stall_seen = 0;
  logic                         calm = 1'b0;

  one_wire_bus_master DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  one_wire_bus_master_check check_u (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .err_count_o    (errors),
    .pending_o      (pending),
    .checked_o      (checked),
    .cmd_count_o    (cmds),
    .reject_count_o (rejects),
    .seq_busy_o     (busy)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // The receiver holds off for a long stretch each time stall_seq moves.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_seq != stall_seen) begin
        stall_seen = stall_seq;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  task automatic put_item(input kind_e k, input logic [7:0] d, input logic lvl);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: k, data_byte: d, bus_level: lvl};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Ticks until the sequencer is idle, with the odd command thrown in while busy.
  task automatic tick_idle(input bit rand_lvl, input logic lvl, input int noise);
    do begin
      if ($urandom_range(99) < noise) begin
        put_item(kind_e'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
      end
      put_item(KIND_TICK, 8'($urandom), rand_lvl ? 1'($urandom) : lvl);
    end while (busy);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_timing();
    cfg_reg_e r;
    tick_idle(1'b1, 1'b0, 0);
    wait_drained();
    r = r.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= slot_cfg[r];
      do @(posedge clk); while (!cfg_ready);
      r = r.next();
    end while (r != r.first());
    cfg_valid <= 1'b0;
    settings_n++;
  endtask

  task automatic pick_timing(input bit minimum);
    slot_cfg[CFG_RESET_LOW]     = 48'(minimum ? 1 : $urandom_range(1, 4));
    slot_cfg[CFG_RESET_SAMPLE]  = 48'(minimum ? 1 : $urandom_range(1, 4));
    slot_cfg[CFG_RESET_RECOVER] = 48'(minimum ? 0 : $urandom_range(0, 4));
    slot_cfg[CFG_W1_LOW]        = 48'(minimum ? 1 : $urandom_range(1, 3));
    slot_cfg[CFG_W1_HIGH]       = 48'(minimum ? 0 : $urandom_range(0, 3));
    slot_cfg[CFG_W0_LOW]        = 48'(minimum ? 1 : $urandom_range(1, 3));
    slot_cfg[CFG_W0_HIGH]       = 48'(minimum ? 0 : $urandom_range(0, 3));
    slot_cfg[CFG_READ_SLOT]     = minimum ? '0 : {16'($urandom_range(0, 3)),
                                                  16'($urandom_range(0, 3)),
                                                  16'($urandom_range(0, 3))};
  endtask

  initial begin : stimulus
    int goal;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Read slot timing straight out of reset.
    put_item(KIND_READ, 8'($urandom), 1'($urandom));
    tick_idle(1'b1, 1'b0, 2);

    // Short slots with zero-length phases and a zero read low time.
    slot_cfg[CFG_RESET_LOW]     = 48'd1;
    slot_cfg[CFG_RESET_SAMPLE]  = 48'd1;
    slot_cfg[CFG_RESET_RECOVER] = 48'd0;
    slot_cfg[CFG_W1_LOW]        = 48'd1;
    slot_cfg[CFG_W1_HIGH]       = 48'd0;
    slot_cfg[CFG_W0_LOW]        = 48'd1;
    slot_cfg[CFG_W0_HIGH]       = 48'd1;
    slot_cfg[CFG_READ_SLOT]     = '0;
    load_timing();
    put_item(KIND_TICK, 8'hFF, 1'b1);
    put_item(KIND_RESET, 8'h00, 1'b1);
    put_item(KIND_WRITE, 8'hFF, 1'b0);
    tick_idle(1'b0, 1'b1, 0);
    put_item(KIND_RESET, 8'hFF, 1'b0);
    tick_idle(1'b0, 1'b0, 0);
    put_item(KIND_WRITE, 8'hA5, 1'b1);
    put_item(KIND_RESET, 8'h00, 1'b0);
    tick_idle(1'b1, 1'b0, 0);
    put_item(KIND_READ, 8'h00, 1'b0);
    put_item(KIND_READ, 8'hFF, 1'b1);
    tick_idle(1'b1, 1'b0, 0);

    // Largest values everywhere except the write slots that get used.
    slot_cfg = '1;
    slot_cfg[CFG_W0_LOW]  = 48'd1;
    slot_cfg[CFG_W0_HIGH] = 48'd0;
    slot_cfg[CFG_W1_LOW]  = 48'd1;
    slot_cfg[CFG_W1_HIGH] = 48'd0;
    load_timing();
    put_item(KIND_WRITE, 8'h00, 1'($urandom));
    tick_idle(1'b1, 1'b0, 0);
    put_item(KIND_WRITE, 8'hFF, 1'($urandom));
    tick_idle(1'b1, 1'b0, 0);

    for (int p = 0; p < 6; p++) begin
      pick_timing(p == 0);
      load_timing();
      calm <= (p == 2);
      if (p == 4) begin
        stall_seq <= stall_seq + 1;
      end
      goal = sent + 130;
      while (sent < goal) begin
        if ($urandom_range(99) < 75) begin
          put_item(kind_e'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
          tick_idle(1'b1, 1'b0, 6);
        end else begin
          put_item(kind_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end
      end
    end

    tick_idle(1'b1, 1'b0, 0);
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d result words: %0d commands run, %0d rejected while busy,",
             checked, cmds, rejects);
    $display("under %0d timing settings including the smallest and largest slots.",
             settings_n);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: one_wire_bus_master.f
+incdir+rtl
rtl/owbm_pkg.sv
rtl/owbm_cfg.sv
rtl/owbm_seq.sv
rtl/one_wire_bus_master.sv
test/one_wire_bus_master_check.sv
test/one_wire_bus_master_test.sv
